@@ design/bcpa_pkg.sv @@
package bcpa_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int MAX_CHUNKS_DEF = 16;
  localparam int FIELD_W        = 4;
  localparam int CFG_W          = 5;
  localparam logic [CFG_W-1:0] CPB_RESET = 5'd16;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_POP_HEAD,
    ST_POP_CHUNK,
    ST_OPEN_LINK,
    ST_REL,
    ST_REL_LINK
  } st_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] blk;
    logic [FIELD_W-1:0] slot;
    logic               retired;
  } res_t;

endpackage

@@ design/bcpa_ram.sv @@
module bcpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wa,
  input  logic [W-1:0]                       wd,
  input  logic                               re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] ra,
  output logic [W-1:0]                       rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

@@ design/bcpa_ctrl.sv @@
module bcpa_ctrl import bcpa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CFG_W-1:0]   cpb,
  input  logic               start,
  input  logic               mode,
  input  logic [FIELD_W-1:0] rel_blk,
  input  logic [FIELD_W-1:0] rel_slot,
  output logic               idle,
  input  logic               res_ready,
  output logic               res_valid,
  output res_t               res
);

  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int NW = $clog2(MAX_CHUNKS + 1);
  localparam int PW = BW + 1;
  localparam int AW = BW + CW;
  localparam int ND = MAX_BLOCKS * MAX_CHUNKS;

  typedef logic [PW-1:0] ptr_t;
  localparam ptr_t NONE_PTR = ptr_t'(1) << BW;

  typedef struct packed {
    logic [NW-1:0] space;
    logic [NW-1:0] used;
    logic [NW-1:0] freed;
    logic [CW-1:0] head;
  } blk_t;

  typedef struct packed {
    logic          busy;
    logic [CW-1:0] nxt;
  } chk_t;

  st_t state, state_next;
  ptr_t newest, newest_next;
  ptr_t reuse_head, reuse_head_next;
  logic [MAX_BLOCKS-1:0] live, live_next;
  logic [BW-1:0] cur_blk, cur_blk_next;
  logic [CW-1:0] cur_slot, cur_slot_next;
  logic rel_ok, rel_ok_next;
  ptr_t aux_ptr, aux_ptr_next;
  ptr_t aux_val, aux_val_next;

  logic blk_we, blk_re;
  logic [BW-1:0] blk_wa, blk_ra;
  blk_t blk_wd, blk_rd;
  logic chk_we, chk_re;
  logic [AW-1:0] chk_wa, chk_ra;
  chk_t chk_wd, chk_rd;
  logic old_we, old_re, new_we, new_re, rnx_we, rnx_re, rpv_we, rpv_re;
  logic [BW-1:0] old_wa, old_ra, new_wa, new_ra, rnx_wa, rnx_ra, rpv_wa, rpv_ra;
  ptr_t old_wd, old_rd, new_wd, new_rd, rnx_wd, rnx_rd, rpv_wd, rpv_rd;

  logic have_free;
  logic [BW-1:0] free_idx;
  logic [NW-1:0] space_new;
  logic [NW-1:0] freed_n;
  logic retire;

  bcpa_ram #(.W($bits(blk_t)), .D(MAX_BLOCKS)) u_blk (
    .clk(clk), .we(blk_we), .wa(blk_wa), .wd(blk_wd), .re(blk_re), .ra(blk_ra), .rd(blk_rd));
  bcpa_ram #(.W($bits(chk_t)), .D(ND)) u_chk (
    .clk(clk), .we(chk_we), .wa(chk_wa), .wd(chk_wd), .re(chk_re), .ra(chk_ra), .rd(chk_rd));
  bcpa_ram #(.W(PW), .D(MAX_BLOCKS)) u_older (
    .clk(clk), .we(old_we), .wa(old_wa), .wd(old_wd), .re(old_re), .ra(old_ra), .rd(old_rd));
  bcpa_ram #(.W(PW), .D(MAX_BLOCKS)) u_newer (
    .clk(clk), .we(new_we), .wa(new_wa), .wd(new_wd), .re(new_re), .ra(new_ra), .rd(new_rd));
  bcpa_ram #(.W(PW), .D(MAX_BLOCKS)) u_rnext (
    .clk(clk), .we(rnx_we), .wa(rnx_wa), .wd(rnx_wd), .re(rnx_re), .ra(rnx_ra), .rd(rnx_rd));
  bcpa_ram #(.W(PW), .D(MAX_BLOCKS)) u_rprev (
    .clk(clk), .we(rpv_we), .wa(rpv_wa), .wd(rpv_wd), .re(rpv_re), .ra(rpv_ra), .rd(rpv_rd));

  // lowest unused block index
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        have_free = 1'b1;
        free_idx  = BW'(i);
      end
    end
  end

  always_comb begin
    if (cpb == '0) begin
      space_new = NW'(1);
    end else if (int'(cpb) > MAX_CHUNKS) begin
      space_new = NW'(MAX_CHUNKS);
    end else begin
      space_new = NW'(cpb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      newest     <= NONE_PTR;
      reuse_head <= NONE_PTR;
      live       <= '0;
    end else begin
      state      <= state_next;
      newest     <= newest_next;
      reuse_head <= reuse_head_next;
      live       <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_blk  <= cur_blk_next;
    cur_slot <= cur_slot_next;
    rel_ok   <= rel_ok_next;
    aux_ptr  <= aux_ptr_next;
    aux_val  <= aux_val_next;
  end

  always_comb begin
    state_next      = state;
    newest_next     = newest;
    reuse_head_next = reuse_head;
    live_next       = live;
    cur_blk_next    = cur_blk;
    cur_slot_next   = cur_slot;
    rel_ok_next     = rel_ok;
    aux_ptr_next    = aux_ptr;
    aux_val_next    = aux_val;
    idle      = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    blk_we = 1'b0; blk_wa = cur_blk; blk_wd = blk_rd; blk_re = 1'b0; blk_ra = cur_blk;
    chk_we = 1'b0; chk_wa = {cur_blk, cur_slot}; chk_wd = chk_rd; chk_re = 1'b0;
    chk_ra = {cur_blk, cur_slot};
    old_we = 1'b0; old_wa = cur_blk; old_wd = NONE_PTR; old_re = 1'b0; old_ra = cur_blk;
    new_we = 1'b0; new_wa = cur_blk; new_wd = NONE_PTR; new_re = 1'b0; new_ra = cur_blk;
    rnx_we = 1'b0; rnx_wa = cur_blk; rnx_wd = NONE_PTR; rnx_re = 1'b0; rnx_ra = cur_blk;
    rpv_we = 1'b0; rpv_wa = cur_blk; rpv_wd = NONE_PTR; rpv_re = 1'b0; rpv_ra = cur_blk;
    freed_n = '0;
    retire  = 1'b0;

    case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          if (mode == MODE_ALLOC) begin
            blk_re = 1'b1;
            blk_ra = newest[BW-1:0];
            state_next = ST_ALLOC;
          end else begin
            cur_blk_next  = rel_blk[BW-1:0];
            cur_slot_next = rel_slot[CW-1:0];
            rel_ok_next   = (int'(rel_blk) < MAX_BLOCKS) && (int'(rel_slot) < MAX_CHUNKS) &&
                            live[rel_blk[BW-1:0]];
            blk_re = 1'b1; blk_ra = rel_blk[BW-1:0];
            chk_re = 1'b1; chk_ra = {rel_blk[BW-1:0], rel_slot[CW-1:0]};
            old_re = 1'b1; old_ra = rel_blk[BW-1:0];
            new_re = 1'b1; new_ra = rel_blk[BW-1:0];
            rnx_re = 1'b1; rnx_ra = rel_blk[BW-1:0];
            rpv_re = 1'b1; rpv_ra = rel_blk[BW-1:0];
            state_next = ST_REL;
          end
        end
      end

      ST_ALLOC: begin
        if (!newest[BW] && (blk_rd.used < blk_rd.space)) begin
          // fresh chunk from the newest block
          if (res_ready) begin
            blk_we = 1'b1;
            blk_wa = newest[BW-1:0];
            blk_wd = blk_rd;
            blk_wd.used = blk_rd.used + NW'(1);
            chk_we = 1'b1;
            chk_wa = {newest[BW-1:0], blk_rd.used[CW-1:0]};
            chk_wd = '{busy: 1'b1, nxt: '0};
            res_valid = 1'b1;
            res = '{ok: 1'b1, blk: FIELD_W'(newest[BW-1:0]),
                    slot: FIELD_W'(blk_rd.used[CW-1:0]), retired: 1'b0};
            state_next = ST_IDLE;
          end
        end else if (!reuse_head[BW]) begin
          blk_re = 1'b1; blk_ra = reuse_head[BW-1:0];
          rnx_re = 1'b1; rnx_ra = reuse_head[BW-1:0];
          cur_blk_next = reuse_head[BW-1:0];
          state_next = ST_POP_HEAD;
        end else if (!have_free) begin
          if (res_ready) begin
            res_valid = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (res_ready) begin
          // open a new block and hand out its first chunk
          live_next[free_idx] = 1'b1;
          blk_we = 1'b1;
          blk_wa = free_idx;
          blk_wd = '{space: space_new, used: NW'(1), freed: '0, head: '0};
          chk_we = 1'b1;
          chk_wa = {free_idx, {CW{1'b0}}};
          chk_wd = '{busy: 1'b1, nxt: '0};
          old_we = 1'b1; old_wa = free_idx; old_wd = newest;
          new_we = 1'b1; new_wa = free_idx; new_wd = NONE_PTR;
          newest_next  = {1'b0, free_idx};
          aux_ptr_next = newest;
          aux_val_next = {1'b0, free_idx};
          res_valid = 1'b1;
          res = '{ok: 1'b1, blk: FIELD_W'(free_idx), slot: '0, retired: 1'b0};
          state_next = ST_OPEN_LINK;
        end
      end

      ST_POP_HEAD: begin
        chk_re = 1'b1;
        chk_ra = {cur_blk, blk_rd.head};
        cur_slot_next = blk_rd.head;
        state_next = ST_POP_CHUNK;
      end

      ST_POP_CHUNK: begin
        if (res_ready) begin
          freed_n = blk_rd.freed - NW'(1);
          blk_we = 1'b1;
          blk_wd = blk_rd;
          blk_wd.freed = freed_n;
          blk_wd.head  = chk_rd.nxt;
          chk_we = 1'b1;
          chk_wd = '{busy: 1'b1, nxt: chk_rd.nxt};
          if (freed_n == '0) begin
            // block drained of free chunks: drop it from the reuse list
            reuse_head_next = rnx_rd;
            if (!rnx_rd[BW]) begin
              rpv_we = 1'b1; rpv_wa = rnx_rd[BW-1:0]; rpv_wd = NONE_PTR;
            end
          end
          res_valid = 1'b1;
          res = '{ok: 1'b1, blk: FIELD_W'(cur_blk), slot: FIELD_W'(cur_slot), retired: 1'b0};
          state_next = ST_IDLE;
        end
      end

      ST_OPEN_LINK: begin
        if (!aux_ptr[BW]) begin
          new_we = 1'b1; new_wa = aux_ptr[BW-1:0]; new_wd = aux_val;
        end
        state_next = ST_IDLE;
      end

      ST_REL: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_next = ST_IDLE;
          if (rel_ok && (int'(cur_slot) < int'(blk_rd.used)) && chk_rd.busy) begin
            freed_n = blk_rd.freed + NW'(1);
            retire  = (freed_n == blk_rd.space);
            chk_we = 1'b1;
            chk_wd = '{busy: 1'b0, nxt: blk_rd.head};
            blk_we = 1'b1;
            blk_wd = blk_rd;
            blk_wd.freed = freed_n;
            blk_wd.head  = cur_slot;
            res = '{ok: 1'b1, blk: '0, slot: '0, retired: retire};
            if (!retire) begin
              if (freed_n == NW'(1)) begin
                // first free chunk: push block on the front of the reuse list
                rpv_we = 1'b1; rpv_wd = NONE_PTR;
                rnx_we = 1'b1; rnx_wd = reuse_head;
                reuse_head_next = {1'b0, cur_blk};
                aux_ptr_next = reuse_head;
                aux_val_next = {1'b0, cur_blk};
                state_next = ST_REL_LINK;
              end
            end else begin
              live_next[cur_blk] = 1'b0;
              if (!old_rd[BW]) begin
                new_we = 1'b1; new_wa = old_rd[BW-1:0]; new_wd = new_rd;
              end
              if (!new_rd[BW]) begin
                old_we = 1'b1; old_wa = new_rd[BW-1:0]; old_wd = old_rd;
              end else begin
                newest_next = old_rd;
              end
              // a block retired on its first free never joined the reuse list
              if (freed_n != NW'(1)) begin
                if (!rpv_rd[BW]) begin
                  rnx_we = 1'b1; rnx_wa = rpv_rd[BW-1:0]; rnx_wd = rnx_rd;
                end else begin
                  reuse_head_next = rnx_rd;
                end
                aux_ptr_next = rnx_rd;
                aux_val_next = rpv_rd;
                state_next = ST_REL_LINK;
              end
            end
          end
        end
      end

      ST_REL_LINK: begin
        if (!aux_ptr[BW]) begin
          rpv_we = 1'b1; rpv_wa = aux_ptr[BW-1:0]; rpv_wd = aux_val;
        end
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/blocked_chunk_pool_allocator.sv @@
// Channel  Direction  Beat contents
// -------  ---------  ---------------------------------------------------------
// s_*      in         one request: tuser = mode, tdata = release_block, slot
// m_*      out        one result per request: tuser = ok, retired; tdata = blk, slot
// cfg_*    in         chunks_per_block, registered on cfg_we, no read-back
//
// Requests are taken one at a time; the tables live in RAMs with a registered read.
// A request reads its tables, then answers; opening a block or a list fix-up on release
// adds a link write after it; a reused chunk reads the block, then the chunk, to answer.
// rst is synchronous: lists empty, no live block, chunks_per_block = 16.
// A stalled result holds the final step of the next request, never earlier steps.
module blocked_chunk_pool_allocator import bcpa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // release_block[3:0], release_slot[7:4]
  input  logic [0:0]       s_tuser,   // mode[0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // grant_block[3:0], grant_slot[7:4]
  output logic [1:0]       m_tuser,   // grant_ok[0], block_retired[1]
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] cpb;
  logic             idle;
  logic             start;
  logic             res_ready;
  logic             res_valid;
  res_t             res;
  res_t             out_res;

  // hold the block size for the next opened block
  always_ff @(posedge clk) begin
    if (rst) begin
      cpb <= CPB_RESET;
    end else if (cfg_we) begin
      cpb <= cfg_wdata;
    end
  end

  assign s_tready  = idle;
  assign start     = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  bcpa_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_CHUNKS(MAX_CHUNKS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cpb       (cpb),
    .start     (start),
    .mode      (s_tuser[0]),
    .rel_blk   (s_tdata[3:0]),
    .rel_slot  (s_tdata[7:4]),
    .idle      (idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register: advance on a new result, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.slot, out_res.blk};
  assign m_tuser = {out_res.retired, out_res.ok};

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == 8'd0) && !m_tuser[1])
    else $error("failed result carries nonzero fields");

  a_retire_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tdata == 8'd0))
    else $error("retire flagged on a result that is not a taken release");

  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (int'(m_tdata[3:0]) < MAX_BLOCKS) &&
                               (int'(m_tdata[7:4]) < MAX_CHUNKS))
    else $error("granted chunk outside the pool");
`endif

endmodule

@@ bench/blocked_chunk_pool_allocator_tb.sv @@
`timescale 1ns / 1ps

module blocked_chunk_pool_allocator_tb;
  import bcpa_pkg::*;

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam int NCHK = MAX_CHUNKS_DEF;
  localparam logic [4:0] NIL = 5'h1F;  // empty list marker

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // release_block[3:0], release_slot[7:4]
  logic [0:0] s_tuser = '0;   // mode[0]
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // grant_block[3:0], grant_slot[7:4]
  logic [1:0] m_tuser;        // grant_ok[0], block_retired[1]
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  blocked_chunk_pool_allocator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the pool: free lists, block age list and reusable list.
  logic [4:0] pool_cfg;
  logic [3:0] nxt_free [NBLK*NCHK];
  bit         busy     [NBLK*NCHK];
  bit         live     [NBLK];
  logic [4:0] space    [NBLK];
  logic [4:0] used     [NBLK];
  logic [4:0] freed    [NBLK];
  logic [4:0] fhead    [NBLK];
  logic [4:0] older    [NBLK];
  logic [4:0] newer    [NBLK];
  logic [4:0] rnext    [NBLK];
  logic [4:0] rprev    [NBLK];
  logic [4:0] newest, rhead;

  res_t grants_due[$];
  int   mismatches = 0;

  // Tracks chunks the bench believes are handed out, for well-formed releases.
  logic [7:0] held[$];

  function automatic void pool_clear();
    pool_cfg = CPB_RESET;
    foreach (busy[i]) begin busy[i] = 0; nxt_free[i] = 0; end
    foreach (live[i]) begin
      live[i] = 0; space[i] = 0; used[i] = 0; freed[i] = 0; fhead[i] = 0;
      older[i] = 0; newer[i] = 0; rnext[i] = 0; rprev[i] = 0;
    end
    newest = NIL; rhead = NIL;
  endfunction

  function automatic res_t pool_step(logic mode, logic [3:0] b, logic [3:0] s);
    res_t r;
    int   ci;
    logic [4:0] sp, c, nx, pv, od, nw;
    r = '0;
    if (mode == MODE_ALLOC) begin
      if (newest != NIL && used[newest] < space[newest]) begin
        r.ok = 1; r.blk = newest[3:0]; r.slot = used[newest][3:0];
        busy[newest*NCHK + used[newest]] = 1; used[newest]++;
        return r;
      end
      if (rhead != NIL) begin
        c = fhead[rhead];
        fhead[rhead] = {1'b0, nxt_free[rhead*NCHK + c]};
        busy[rhead*NCHK + c] = 1;
        freed[rhead]--;
        r.ok = 1; r.blk = rhead[3:0]; r.slot = c[3:0];
        if (freed[rhead] == 0) begin
          nx = rnext[rhead];
          rnext[rhead] = NIL; rprev[rhead] = NIL;
          rhead = nx;
          if (rhead != NIL) rprev[rhead] = NIL;
        end
        return r;
      end
      for (int i = 0; i < NBLK; i++) begin
        if (!live[i]) begin
          sp = pool_cfg;
          if (sp == 0) sp = 5'd1;
          if (sp > NCHK) sp = 5'(NCHK);
          live[i] = 1; space[i] = sp; used[i] = 0; freed[i] = 0; fhead[i] = NIL;
          older[i] = newest; newer[i] = NIL;
          if (newest != NIL) newer[newest] = 5'(i);
          rnext[i] = NIL; rprev[i] = NIL;
          newest = 5'(i);
          r.ok = 1; r.blk = 4'(i); r.slot = 0;
          busy[i*NCHK] = 1; used[i] = 5'd1;
          return r;
        end
      end
      return r;
    end
    ci = b*NCHK + s;
    if (!live[b] || s >= used[b] || !busy[ci]) return r;
    busy[ci] = 0;
    nxt_free[ci] = fhead[b][3:0];
    fhead[b] = {1'b0, s};
    freed[b]++;
    if (freed[b] == 1) begin
      rprev[b] = NIL; rnext[b] = rhead;
      if (rhead != NIL) rprev[rhead] = {1'b0, b};
      rhead = {1'b0, b};
    end
    r.ok = 1;
    if (freed[b] == space[b]) begin
      nx = rnext[b]; pv = rprev[b]; od = older[b]; nw = newer[b];
      if (nx != NIL) rprev[nx] = pv;
      if (pv != NIL) rnext[pv] = nx; else rhead = nx;
      if (od != NIL) newer[od] = nw;
      if (nw != NIL) older[nw] = od; else newest = od;
      live[b] = 0;
      r.retired = 1;
    end
    return r;
  endfunction

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 2);
  endfunction

  bit gaps_on = 1;

  // Send one request beat; predict its grant at the accepting edge.
  // Valid stays up after the beat; the next send replaces it or drops it for a gap, and a drain drops it.
  task automatic send_req(logic mode, logic [3:0] b, logic [3:0] s);
    int gap;
    gap = gaps_on ? short_or_long_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {s, b};
    do @(posedge clk); while (!s_tready);
    grants_due.push_back(pool_step(mode, b, s));
    if (mode == MODE_ALLOC && grants_due[$].ok)
      held.push_back({grants_due[$].slot, grants_due[$].blk});
  endtask

  task automatic alloc_req();
    send_req(MODE_ALLOC, 4'd0, 4'd0);
  endtask

  // Release a random held chunk and drop it from the held list.
  task automatic release_held();
    int k;
    logic [7:0] c;
    if (held.size() == 0) begin alloc_req(); return; end
    k = $urandom_range(0, held.size() - 1);
    c = held[k];
    held.delete(k);
    send_req(MODE_RELEASE, c[3:0], c[7:4]);
  endtask

  // Hold until every grant is back, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [4:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pool_cfg = v;
  endtask

  // Result sink: random stalls, compare each grant beat with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected grant beat %h/%h", m_tuser, m_tdata);
        end else begin
          want = grants_due.pop_front();
          if (m_tuser[0] !== want.ok || m_tdata[3:0] !== want.blk ||
              m_tdata[7:4] !== want.slot || m_tuser[1] !== want.retired) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"grant mismatch: exp ok=%0d blk=%0d slot=%0d ret=%0d, ",
                        "got ok=%0d blk=%0d slot=%0d ret=%0d"},
                       want.ok, want.blk, want.slot, want.retired,
                       m_tuser[0], m_tdata[3:0], m_tdata[7:4], m_tuser[1]);
          end
        end
      end
      m_tready <= gaps_on ? (short_or_long_gap() == 0) : 1'b1;
    end
  end

  // Directed: fill the pool with single-chunk blocks, overflow, release to retire.
  task automatic test_full_pool();
    write_cfg(5'd0);                 // zero counts as one chunk
    repeat (NBLK + 1) alloc_req();   // last one finds no free slot
    send_req(MODE_RELEASE, 4'd15, 4'd0);   // single-chunk block retires at once
    send_req(MODE_RELEASE, 4'd15, 4'd0);   // now not live: ignored
    send_req(MODE_RELEASE, 4'd3, 4'd15);   // beyond used count: ignored
    drain();
    held.delete();
    while (newest != NIL || live[0]) begin
      for (int i = 0; i < NBLK; i++)
        if (live[i]) send_req(MODE_RELEASE, 4'(i), 4'd0);
    end
  endtask

  // Directed: large blocks, double release, reuse pop order.
  task automatic test_reuse();
    write_cfg(5'd31);                // above max counts as the max
    repeat (NCHK + 2) alloc_req();
    send_req(MODE_RELEASE, 4'd0, 4'd5);
    send_req(MODE_RELEASE, 4'd0, 4'd5);    // already freed: ignored
    send_req(MODE_RELEASE, 4'd0, 4'd15);
    send_req(MODE_RELEASE, 4'd1, 4'd14);   // never granted: ignored
    drain();
    held.delete();
    for (int i = 0; i < NBLK; i++)
      for (int j = 0; j < NCHK; j++)
        if (live[i] && busy[i*NCHK + j]) held.push_back({j[3:0], i[3:0]});
  endtask

  // Random traffic: allocations and valid releases of held chunks, some noise.
  task automatic test_random(int n, logic [4:0] cpb);
    int pick;
    write_cfg(cpb);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) alloc_req();
      else if (pick < 90) release_held();
      else send_req(MODE_RELEASE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      if (k == n/2) drain();    // pause until every grant is back
    end
  endtask

  // Random noise releases may have freed chunks we thought were held; resync.
  always @(posedge clk) begin
    if (held.size() != 0 && !busy[held[0][3:0]*NCHK + held[0][7:4]]) void'(held.pop_front());
  end

  initial begin
    pool_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_pool();
    test_reuse();
    test_random(100, 5'd1);
    test_random(120, 5'd4);
    gaps_on = 0;
    test_random(40, 5'd16);    // back-to-back stretch
    gaps_on = 1;
    test_random(140, 5'd7);
    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
design/bcpa_pkg.sv
design/bcpa_ram.sv
design/bcpa_ctrl.sv
design/blocked_chunk_pool_allocator.sv
bench/blocked_chunk_pool_allocator_tb.sv
